FILE: hdl/pqkd_pkg.sv
package pqkd_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NAME_BYTES_DEF  = 8;

    localparam int NAME_W = 64;
    localparam int PID_W  = 22;
    localparam int PRI_W  = 8;
    localparam int RUN_W  = 16;
    localparam int OCC_W  = 5;

    localparam logic [1:0] CMD_PUSH     = 2'd0;
    localparam logic [1:0] CMD_POP      = 2'd1;
    localparam logic [1:0] CMD_DEL_NAME = 2'd2;
    localparam logic [1:0] CMD_DEL_PID  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_EMPTY    = 2'd1;
    localparam logic [1:0] STAT_NOTFOUND = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [NAME_W-1:0] key_name;
        logic [PID_W-1:0]  key_pid;
        logic [PRI_W-1:0]  new_priority;
        logic [RUN_W-1:0]  new_runtime;
    } t_pq_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [NAME_W-1:0] out_name;
        logic [PID_W-1:0]  out_pid;
        logic [PRI_W-1:0]  out_priority;
        logic [RUN_W-1:0]  out_runtime;
        logic [OCC_W-1:0]  occupancy;
    } t_pq_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    // Keeps at most nbytes bytes and clears every byte from the first zero byte on.
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] v,
                                                     input int nbytes);
        logic [NAME_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < NAME_W / 8; b++) begin
            if (b >= nbytes || v[b*8 +: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[b*8 +: 8] = v[b*8 +: 8];
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/pqkd_ram.sv
module pqkd_ram import pqkd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int WIDTH = NAME_BYTES_DEF * 8 + PID_W + PRI_W + RUN_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pqkd_ctrl.sv
module pqkd_ctrl import pqkd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int RW = NAME_BYTES * 8 + PID_W + PRI_W + RUN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  t_pq_in        i_data,
    output logic          o_res_valid,
    output t_pq_out       o_res,
    input  logic          i_res_ready,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [RW-1:0] o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [RW-1:0] i_rdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + 1;
    localparam int NW = NAME_BYTES * 8;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    logic [1:0]         r_cmd, n_cmd;
    logic [NW-1:0]      r_key_name, n_key_name;
    logic [PID_W-1:0]   r_key_pid, n_key_pid;
    t_pq_out            r_res, n_res;

    logic [NAME_W-1:0]  w_canon;
    logic [NW-1:0]      w_rd_name;
    logic [PID_W-1:0]   w_rd_pid;
    logic [PRI_W-1:0]   w_rd_pri;
    logic [RUN_W-1:0]   w_rd_run;
    logic [XW-1:0]      w_pos1, w_pos2, w_cnt;
    logic               w_hit;

    assign w_canon   = canon_name(i_data.key_name, NAME_BYTES);
    assign w_rd_name = i_rdata[RW-1 -: NW];
    assign w_rd_pid  = i_rdata[PID_W+PRI_W+RUN_W-1 -: PID_W];
    assign w_rd_pri  = i_rdata[PRI_W+RUN_W-1 -: PRI_W];
    assign w_rd_run  = i_rdata[RUN_W-1:0];
    assign w_pos1    = XW'(r_pos) + XW'(1);
    assign w_pos2    = XW'(r_pos) + XW'(2);
    assign w_cnt     = XW'(r_count);
    assign w_hit     = (r_cmd == CMD_POP) ||
                       ((r_cmd == CMD_DEL_NAME) && (w_rd_name == r_key_name)) ||
                       ((r_cmd == CMD_DEL_PID) && (w_rd_pid == r_key_pid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_cmd      <= n_cmd;
        r_key_name <= n_key_name;
        r_key_pid  <= n_key_pid;
        r_res      <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_cmd       = r_cmd;
        n_key_name  = r_key_name;
        n_key_pid   = r_key_pid;
        n_res       = r_res;
        o_stall     = 1'b1;
        o_res_valid = 1'b0;
        o_we        = 1'b0;
        o_waddr     = r_pos;
        o_wdata     = i_rdata;
        o_raddr     = '0;

        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_cmd      = i_data.cmd;
                    n_key_name = w_canon[NW-1:0];
                    n_key_pid  = i_data.key_pid;
                    n_res      = '0;
                    n_pos      = '0;
                    n_state    = S_DONE;
                    if (i_data.cmd == CMD_PUSH) begin
                        if (r_count == CW'(QUEUE_DEPTH)) begin
                            n_res.status = STAT_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = r_count[AW-1:0];
                            o_wdata = {w_canon[NW-1:0], i_data.key_pid,
                                       i_data.new_priority, i_data.new_runtime};
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_res.status = (i_data.cmd == CMD_POP) ? STAT_EMPTY : STAT_NOTFOUND;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (w_hit) begin
                    n_res.out_name     = NAME_W'(w_rd_name);
                    n_res.out_pid      = w_rd_pid;
                    n_res.out_priority = w_rd_pri;
                    n_res.out_runtime  = w_rd_run;
                    if (w_pos1 >= w_cnt) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        o_raddr = w_pos1[AW-1:0];
                        n_state = S_SHIFT;
                    end
                end else if (w_pos1 >= w_cnt) begin
                    n_res.status = STAT_NOTFOUND;
                    n_state      = S_DONE;
                end else begin
                    o_raddr = w_pos1[AW-1:0];
                    n_pos   = w_pos1[AW-1:0];
                end
            end
            S_SHIFT: begin
                o_we = 1'b1;
                if (w_pos2 >= w_cnt) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    o_raddr = w_pos2[AW-1:0];
                    n_pos   = w_pos1[AW-1:0];
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res           = r_res;
        o_res.occupancy = OCC_W'(r_count);
    end

endmodule

FILE: hdl/process_queue_with_keyed_delete.sv
// Bounded queue of process records with push, pop and search-and-delete.
// Input channel: i_valid, o_stall, i_data. One beat carries one command.
// Output channel: o_valid, i_stall, o_data. Every command gives exactly one beat
// with a status, the removed record (zero when nothing was removed) and the
// number of records held afterwards.
// Push and commands on an empty queue go straight to the done state; their result
// then moves into the output register. Pop and the keyed deletes read the record
// store one entry per cycle: the search walks from the head until the first match,
// then every later record is moved one place toward the head, one per cycle,
// through the single read port and single write port of the store.
// One command is in work at a time; the next beat is taken once the result of
// the previous one has moved into the output register.
// A result waits in the output register while i_stall is high, and the block
// can finish the following command meanwhile, holding it until the register
// frees. Reset empties the queue; the record store itself is not cleared.
module process_queue_with_keyed_delete import pqkd_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_pq_in  i_data,
    output logic    o_valid,
    input  logic    i_stall,
    output t_pq_out o_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int RW = NAME_BYTES * 8 + PID_W + PRI_W + RUN_W;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [RW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [RW-1:0] w_rdata;
    logic          w_res_valid;
    logic          w_res_ready;
    t_pq_out       w_res;

    logic          r_out_valid;
    t_pq_out       r_out;

    pqkd_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    pqkd_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (RW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_res_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_full_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == STAT_FULL) |-> (o_data.occupancy == OCC_W'(QUEUE_DEPTH)))
        else $error("full status with a queue that is not full");

    a_empty_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == STAT_EMPTY) |-> (o_data.occupancy == '0))
        else $error("empty status with records held");

    a_busy_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> o_stall)
        else $error("input taken while a result is pending");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_valid)
        else $error("result lost on the way to the output register");

endmodule

FILE: test/pq_scoreboard_pkg.sv
package pq_scoreboard_pkg;

    import pqkd_pkg::*;

    class record_queue_checker;

        logic [NAME_W-1:0] shadow_names[QUEUE_DEPTH_DEF];
        logic [PID_W-1:0]  shadow_pids[QUEUE_DEPTH_DEF];
        logic [PRI_W-1:0]  shadow_pris[QUEUE_DEPTH_DEF];
        logic [RUN_W-1:0]  shadow_runs[QUEUE_DEPTH_DEF];
        int unsigned       held;
        int unsigned       peak_held;
        int unsigned       status_seen[4];
        int unsigned       commands;
        int unsigned       errors;
        t_pq_out           due_results[$];

        function new();
            held      = 0;
            peak_held = 0;
            commands  = 0;
            errors    = 0;
            foreach (status_seen[s]) begin
                status_seen[s] = 0;
            end
        endfunction

        // Names compare as strings: bytes past the first zero byte do not count.
        function logic [NAME_W-1:0] trimmed(input logic [NAME_W-1:0] v);
            logic [NAME_W-1:0] r;
            r = '0;
            for (int b = 0; b < NAME_BYTES_DEF; b++) begin
                if (v[b*8 +: 8] == 8'd0) begin
                    break;
                end
                r[b*8 +: 8] = v[b*8 +: 8];
            end
            return r;
        endfunction

        function void take_out(input int pos, inout t_pq_out r);
            r.out_name     = shadow_names[pos];
            r.out_pid      = shadow_pids[pos];
            r.out_priority = shadow_pris[pos];
            r.out_runtime  = shadow_runs[pos];
            for (int i = pos; i + 1 < int'(held); i++) begin
                shadow_names[i] = shadow_names[i+1];
                shadow_pids[i]  = shadow_pids[i+1];
                shadow_pris[i]  = shadow_pris[i+1];
                shadow_runs[i]  = shadow_runs[i+1];
            end
            held--;
        endfunction

        function void note_command(input t_pq_in beat);
            t_pq_out           r;
            logic [NAME_W-1:0] key;
            int                pos;
            r      = '0;
            key    = trimmed(beat.key_name);
            pos    = -1;
            r.status = STAT_OK;
            case (beat.cmd)
                CMD_PUSH: begin
                    if (held >= QUEUE_DEPTH_DEF) begin
                        r.status = STAT_FULL;
                    end else begin
                        shadow_names[held] = key;
                        shadow_pids[held]  = beat.key_pid;
                        shadow_pris[held]  = beat.new_priority;
                        shadow_runs[held]  = beat.new_runtime;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        take_out(0, r);
                    end
                end
                default: begin
                    for (int i = 0; i < int'(held); i++) begin
                        if ((beat.cmd == CMD_DEL_NAME) ? (shadow_names[i] == key)
                                                       : (shadow_pids[i] == beat.key_pid)) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos >= 0) begin
                        take_out(pos, r);
                    end else begin
                        r.status = STAT_NOTFOUND;
                    end
                end
            endcase
            r.occupancy = OCC_W'(held);
            if (held > peak_held) begin
                peak_held = held;
            end
            status_seen[r.status]++;
            commands++;
            due_results.push_back(r);
        endfunction

        function void compare_field(input string label, input logic [NAME_W-1:0] want,
                                    input logic [NAME_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            end
        endfunction

        function void check_result(input t_pq_out got);
            t_pq_out want;
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = due_results.pop_front();
            compare_field("status", NAME_W'(want.status), NAME_W'(got.status));
            compare_field("out_name", want.out_name, got.out_name);
            compare_field("out_pid", NAME_W'(want.out_pid), NAME_W'(got.out_pid));
            compare_field("out_priority", NAME_W'(want.out_priority),
                          NAME_W'(got.out_priority));
            compare_field("out_runtime", NAME_W'(want.out_runtime),
                          NAME_W'(got.out_runtime));
            compare_field("occupancy", NAME_W'(want.occupancy), NAME_W'(got.occupancy));
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        function logic [NAME_W-1:0] stored_name();
            if (held == 0) begin
                return '0;
            end
            return shadow_names[$urandom_range(held - 1)];
        endfunction

        function logic [PID_W-1:0] stored_pid();
            if (held == 0) begin
                return '0;
            end
            return shadow_pids[$urandom_range(held - 1)];
        endfunction

    endclass

endpackage

FILE: test/tb_top.sv
module tb_top;

    import pqkd_pkg::*;
    import pq_scoreboard_pkg::*;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_pq_in  i_data;
    logic    o_valid;
    logic    i_stall = 1'b0;
    t_pq_out o_data;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned idle_tab[4]    = '{0, 54, 0, 19};
    int unsigned stall_tab[4]   = '{0, 0, 54, 19};
    bit          filling        = 1'b1;

    record_queue_checker chk;

    process_queue_with_keyed_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            chk.check_result(o_data);
        end
    end

    initial begin
        #7_200_000;
        $display("Run timed out with %0d results outstanding.", chk.pending());
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_pq_in make_beat(input logic [1:0] cmd, input logic [NAME_W-1:0] name,
                                         input logic [PID_W-1:0] pid,
                                         input logic [PRI_W-1:0] pri,
                                         input logic [RUN_W-1:0] run);
        t_pq_in b;
        b.cmd          = cmd;
        b.key_name     = name;
        b.key_pid      = pid;
        b.new_priority = pri;
        b.new_runtime  = run;
        return b;
    endfunction

    function automatic logic [NAME_W-1:0] smear_tail(input logic [NAME_W-1:0] n);
        logic [NAME_W-1:0] r;
        int                z;
        r = n;
        z = 8;
        for (int b = 7; b >= 0; b--) begin
            if (n[b*8 +: 8] == 8'd0) begin
                z = b;
            end
        end
        if (z < 7 && $urandom_range(1) == 1) begin
            for (int b = z + 1; b < 8; b++) begin
                r[b*8 +: 8] = 8'($urandom);
            end
        end
        return r;
    endfunction

    function automatic logic [NAME_W-1:0] make_name();
        logic [NAME_W-1:0] n;
        int                len;
        bit                narrow;
        n      = '0;
        len    = $urandom_range(8);
        narrow = ($urandom_range(2) != 0);
        if ($urandom_range(9) == 0) begin
            return {$urandom, $urandom};
        end
        for (int b = 0; b < len; b++) begin
            n[b*8 +: 8] = narrow ? 8'(8'h61 + $urandom_range(1)) : 8'($urandom_range(255, 1));
        end
        return smear_tail(n);
    endfunction

    function automatic logic [PID_W-1:0] make_pid();
        if ($urandom_range(1) == 0) begin
            return PID_W'($urandom_range(7));
        end
        return PID_W'($urandom);
    endfunction

    function automatic t_pq_in random_beat();
        int unsigned push_pct;
        int unsigned pick;
        logic [1:0]  cmd;
        t_pq_in      b;
        if ($urandom_range(99) < 5) begin
            return make_beat(2'($urandom), {$urandom, $urandom}, PID_W'($urandom),
                             PRI_W'($urandom), RUN_W'($urandom));
        end
        if (chk.held == QUEUE_DEPTH_DEF && $urandom_range(2) == 0) begin
            filling = 1'b0;
        end else if (chk.held == 0 && $urandom_range(2) == 0) begin
            filling = 1'b1;
        end
        push_pct = filling ? 70 : 25;
        pick     = $urandom_range(2);
        if ($urandom_range(99) < push_pct) begin
            cmd = CMD_PUSH;
        end else if (pick == 0) begin
            cmd = CMD_POP;
        end else if (pick == 1) begin
            cmd = CMD_DEL_NAME;
        end else begin
            cmd = CMD_DEL_PID;
        end
        b = make_beat(cmd, make_name(), make_pid(), PRI_W'($urandom), RUN_W'($urandom));
        if ((cmd == CMD_DEL_NAME || cmd == CMD_DEL_PID) && $urandom_range(9) < 8) begin
            b.key_name = smear_tail(chk.stored_name());
            b.key_pid  = chk.stored_pid();
        end
        return b;
    endfunction

    task automatic send_beat(input t_pq_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= beat;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        chk.note_command(beat);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (chk.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        logic [NAME_W-1:0] name;
        logic [PID_W-1:0]  pid;
        send_beat(make_beat(CMD_POP, '0, '0, '0, '0));
        send_beat(make_beat(CMD_DEL_NAME, '1, '0, '0, '0));
        send_beat(make_beat(CMD_DEL_PID, '0, '1, '0, '0));
        for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
            case (i)
                0:       name = '1;
                1:       name = '0;
                2:       name = 64'hDEAD_BEEF_CAFE_0041;
                default: name = {$urandom, $urandom};
            endcase
            pid = (i == 1) ? '1 : PID_W'(i);
            send_beat(make_beat(CMD_PUSH, name, pid, (i % 2 == 0) ? '0 : '1,
                                (i % 2 == 0) ? '1 : '0));
        end
        send_beat(make_beat(CMD_PUSH, '1, '1, '1, '1));
        send_beat(make_beat(CMD_DEL_NAME, 64'h1234_5678_9ABC_0041, '0, '0, '0));
        send_beat(make_beat(CMD_DEL_PID, '0, '1, '0, '0));
        send_beat(make_beat(CMD_DEL_PID, '0, 22'h155555, '0, '0));
        send_beat(make_beat(CMD_DEL_NAME, 64'h0000_0000_0000_5A5A, '0, '0, '0));
        send_beat(make_beat(CMD_POP, '0, '0, '0, '0));
    endtask

    initial begin
        chk     = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain_results();
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_tab[phase];
            recv_stall_pct = stall_tab[phase];
            for (int n = 0; n < 120; n++) begin
                send_beat(random_beat());
                if ($urandom_range(99) == 0) begin
                    drain_results();
                end
            end
            drain_results();
        end
        recv_stall_pct = 0;
        repeat (40) @(posedge i_clk);
        $display("Ran %0d queue commands over four traffic phases, peak occupancy %0d.",
                 chk.commands, chk.peak_held);
        $display("Statuses: ok %0d, empty %0d, not found %0d, full %0d; %0d errors.",
                 chk.status_seen[STAT_OK], chk.status_seen[STAT_EMPTY],
                 chk.status_seen[STAT_NOTFOUND], chk.status_seen[STAT_FULL], chk.errors);
        if (chk.errors == 0 && chk.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
